// ===== sv/utf8_stream_validator_defines.svh =====
// assertion macros for the utf8 stream validator checker
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication, masked while in reset
`define UTF8V_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8v check failed");

// next-cycle implication, masked while in reset
`define UTF8V_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8v check failed");

`endif

// ===== sv/utf8v_pkg.sv =====
// shared types and byte constants for the utf8 stream validator
// no dependencies
package utf8v_pkg;

    localparam int MAX_LEN_DEFAULT = 65536;
    localparam int POS_W           = 16;

    typedef logic [7:0]       t_byte;
    typedef logic [1:0]       t_pending;
    typedef logic [POS_W-1:0] t_pos;

    // lead and continuation bytes with special meaning
    localparam t_byte C_BYTE_NUL      = 8'h00;
    localparam t_byte C_LEAD_E0       = 8'he0;
    localparam t_byte C_LEAD_ED       = 8'hed;
    localparam t_byte C_LEAD_EF       = 8'hef;
    localparam t_byte C_LEAD_F0       = 8'hf0;
    localparam t_byte C_LEAD_F4       = 8'hf4;
    localparam t_byte C_CONT_LO       = 8'h80;
    localparam t_byte C_CONT_HI       = 8'hbf;
    localparam t_byte C_OVERLONG2_LO  = 8'hc0;
    localparam t_byte C_OVERLONG2_HI  = 8'hc1;
    localparam t_byte C_LEAD_BAD_LO   = 8'hf5;
    localparam t_byte C_LEAD_BAD_HI   = 8'hff;
    localparam t_byte C_CONT_F4_MAX   = 8'h8f;
    localparam t_byte C_NONCHAR_LO    = 8'hbe;

    typedef struct packed {
        t_pending pending;
        t_byte    lead;
        t_byte    second;
        t_pos     pos;
        t_pos     seq_start;
        logic     err;
        t_pos     err_pos;
        logic     ended;
    } t_scan_state;

endpackage

// ===== sv/utf8v_if.sv =====
// request and result channel interfaces for the utf8 stream validator
// depends on utf8v_pkg
interface utf8v_req_if
    import utf8v_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface utf8v_res_if
    import utf8v_pkg::*;
();
    logic valid;
    logic ready;
    logic is_valid;
    t_pos bad_offset;

    modport source (output valid, output is_valid, output bad_offset, input ready);
    modport sink   (input valid, input is_valid, input bad_offset, output ready);
endinterface

// ===== sv/utf8_stream_validator.sv =====
// UTF-8 validator: one byte per request, a result on each request with frame_last set.
// The path from request to result is an input register, then a result register;
// a request is taken every cycle while results drain, and only a last-byte request waits
// on a full result register. Offsets count every byte of the frame and saturate at the
// smaller of MAX_LEN-1 and 65535. A zero byte ends the string; later bytes are ignored.
// Depends on utf8v_pkg and utf8v_if.
module utf8_stream_validator
    import utf8v_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8v_req_if.sink    i_req,
    utf8v_res_if.source  o_res
);

    localparam int   POS_MAX   = (1 << POS_W) - 1;
    localparam t_pos POS_LIMIT = t_pos'(((MAX_LEN - 1) > POS_MAX) ? POS_MAX : (MAX_LEN - 1));

    logic        r_s1_valid;
    t_byte       r_s1_byte;
    logic        r_s1_last;
    t_scan_state r_st;
    t_scan_state n_st;
    logic        r_out_valid;
    logic        r_out_is_valid;
    t_pos        r_out_off;
    logic        n_out_is_valid;
    t_pos        n_out_off;

    logic        s1_fire;
    logic        three;
    logic        bad;

    // last-byte requests need a free result slot
    assign s1_fire     = r_s1_valid && (!r_s1_last || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;

    always_comb begin
        n_st           = r_st;
        three          = (r_st.lead[7:4] == 4'he);
        bad            = 1'b0;
        n_out_is_valid = 1'b1;
        n_out_off      = '0;

        if (!r_st.err && !r_st.ended) begin
            if (r_st.pending == 2'd0) begin
                n_st.seq_start = r_st.pos;
                n_st.lead      = r_s1_byte;
                if (r_s1_byte == C_BYTE_NUL) begin
                    n_st.ended = 1'b1;
                end else if (!r_s1_byte[7]) begin
                    n_st.pending = 2'd0;
                end else if (r_s1_byte inside {[C_CONT_LO:C_CONT_HI],
                                               [C_OVERLONG2_LO:C_OVERLONG2_HI],
                                               [C_LEAD_BAD_LO:C_LEAD_BAD_HI]}) begin
                    n_st.err     = 1'b1;
                    n_st.err_pos = r_st.pos;
                    n_st.pending = 2'd0;
                end else if (r_s1_byte[7:5] == 3'b110) begin
                    n_st.pending = 2'd1;
                end else if (r_s1_byte[7:4] == 4'he) begin
                    n_st.pending = 2'd2;
                end else begin
                    n_st.pending = 2'd3;
                end
            end else begin
                if (r_s1_byte == C_BYTE_NUL) begin
                    n_st.ended = 1'b1;
                    bad        = 1'b1;
                end else if (r_s1_byte[7:6] != 2'b10) begin
                    bad = 1'b1;
                end else if (three && r_st.pending == 2'd2) begin
                    n_st.second = r_s1_byte;
                    bad = (r_st.lead == C_LEAD_E0 && r_s1_byte[7:5] == 3'b100)
                       || (r_st.lead == C_LEAD_ED && r_s1_byte[7:5] == 3'b101);
                end else if (three && r_st.pending == 2'd1) begin
                    // U+FFFE and U+FFFF
                    bad = r_st.lead == C_LEAD_EF && r_st.second == C_CONT_HI
                       && r_s1_byte[7:1] == C_NONCHAR_LO[7:1];
                end else if (r_st.pending == 2'd3) begin
                    n_st.second = r_s1_byte;
                    bad = (r_st.lead == C_LEAD_F0 && r_s1_byte[7:4] == 4'h8)
                       || (r_st.lead == C_LEAD_F4 && r_s1_byte > C_CONT_F4_MAX);
                end
                if (bad) begin
                    n_st.err     = 1'b1;
                    n_st.err_pos = r_st.seq_start;
                    n_st.pending = 2'd0;
                end else begin
                    n_st.pending = r_st.pending - 2'd1;
                end
            end
        end

        if (r_st.pos < POS_LIMIT) begin
            n_st.pos = r_st.pos + t_pos'(1);
        end

        if (r_s1_last) begin
            // frame ended inside a sequence
            if (!n_st.err && n_st.pending != 2'd0) begin
                n_st.err     = 1'b1;
                n_st.err_pos = n_st.seq_start;
            end
            n_out_is_valid = !n_st.err;
            n_out_off      = n_st.err ? n_st.err_pos : '0;
            n_st           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_fire) begin
                r_st <= n_st;
            end
            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_byte <= i_req.data_byte;
            r_s1_last <= i_req.frame_last;
        end
        if (s1_fire && r_s1_last) begin
            r_out_is_valid <= n_out_is_valid;
            r_out_off      <= n_out_off;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.is_valid   = r_out_is_valid;
    assign o_res.bad_offset = r_out_off;

endmodule

// ===== sv/utf8v_checker.sv =====
// port-level checks for the utf8 stream validator, bound to the top level
// depends on utf8v_pkg and utf8_stream_validator_defines.svh
`include "utf8_stream_validator_defines.svh"

module utf8v_checker
    import utf8v_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_is_valid,
    input t_pos i_res_bad_offset
);

    // a stalled result holds
    `UTF8V_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_is_valid) && $stable(i_res_bad_offset))

    // good strings report offset zero
    `UTF8V_ASSERT_NOW(a_valid_zero_off, i_res_valid && i_res_is_valid, i_res_bad_offset == '0)

    // with the result slot empty the input never stalls
    `UTF8V_ASSERT_NOW(a_ready_when_empty, !i_res_valid, i_req_ready)

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_ready      (i_req.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_is_valid   (o_res.is_valid),
    .i_res_bad_offset (o_res.bad_offset)
);
